/* hw/rtl/ray_box_slab_test_assert.svh */
// Assertion macros shared by the checker of the ray / box slab test.
// Depends on nothing; included by the checker file.
`ifndef RAY_BOX_SLAB_TEST_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define RBST_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Condition that must hold at every clock edge outside reset.
`define RBST_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

/* hw/rtl/rbst_pkg.sv */
// Package of the ray / box slab test: default widths and shared types.
// Depends on nothing.
`default_nettype none
package rbst_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int LATENCY = 3;

  typedef struct packed {
    logic bounded;
    logic pass;
  } rbst_flags_t;
endpackage
`default_nettype wire

/* hw/rtl/rbst_lane.sv */
// One axis lane: forms the slab interval ends as numerator over a non-negative denominator (zero for zero direction).
// Depends on rbst_pkg.
`default_nettype none
module rbst_lane #(
  parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic signed [COORD_BITS-1:0] bmin,
  input  wire logic signed [COORD_BITS-1:0] bmax,
  input  wire logic signed [COORD_BITS-1:0] org,
  input  wire logic signed [COORD_BITS-1:0] dir,
  output logic signed [COORD_BITS:0]        lo_num,
  output logic signed [COORD_BITS:0]        hi_num,
  output logic signed [COORD_BITS:0]        den,
  output rbst_pkg::rbst_flags_t             flags
);
  logic signed [COORD_BITS:0] bmin_e, bmax_e, org_e, dir_e;

  assign bmin_e = {bmin[COORD_BITS-1], bmin};
  assign bmax_e = {bmax[COORD_BITS-1], bmax};
  assign org_e  = {org[COORD_BITS-1], org};
  assign dir_e  = {dir[COORD_BITS-1], dir};

  always_ff @(posedge clk) begin
    if (dir[COORD_BITS-1]) begin
      lo_num <= org_e - bmax_e;
      hi_num <= org_e - bmin_e;
      den    <= -dir_e;
    end else begin
      lo_num <= bmin_e - org_e;
      hi_num <= bmax_e - org_e;
      den    <= dir_e;
    end
    flags.bounded <= (dir != '0);
    flags.pass    <= (dir != '0) || ((bmin <= org) && (org <= bmax));
  end
endmodule
`default_nettype wire

/* hw/rtl/rbst_pair_cmp.sv */
// Exact comparison lo_i <= hi_j of two rationals by registered cross products.
// Depends on rbst_pkg.
`default_nettype none
module rbst_pair_cmp #(
  parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic signed [COORD_BITS:0] lo_num,
  input  wire logic signed [COORD_BITS:0] lo_den,
  input  wire logic signed [COORD_BITS:0] hi_num,
  input  wire logic signed [COORD_BITS:0] hi_den,
  output logic                            le
);
  logic signed [2*COORD_BITS+1:0] prod_l, prod_r;

  // Where both denominators are positive, the cross products compare like the ratios.
  always_ff @(posedge clk) begin
    prod_l <= lo_num * hi_den;
    prod_r <= hi_num * lo_den;
  end

  assign le = (prod_l <= prod_r);
endmodule
`default_nettype wire

/* hw/rtl/ray_box_slab_test.sv */
// Top level of the ray / box slab test: three axis lanes and the merging stage.
// Depends on rbst_pkg, rbst_lane and rbst_pair_cmp.
`default_nettype none
// A ray and a box are taken in one beat whenever start is high; busy never
// rises, so a new test may be issued in every cycle. The verdict appears on
// hit from the output register, marked by valid for exactly one cycle, and
// must be taken then, as the block cannot be stalled. The lane registers form
// the slab ends of each axis in its own lane, the product registers hold the
// cross products of every lower end against every upper end, and the output
// register combines them with the zero-direction checks into the verdict.
// The line meets the box exactly when every lower end is at most every upper
// end, which equals the largest lower end lying at or below the smallest upper
// end; comparing all nine pairs at once keeps the path to one multiplier.
module ray_box_slab_test #(
  parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] box_min_x,
  input  wire logic signed [COORD_BITS-1:0] box_min_y,
  input  wire logic signed [COORD_BITS-1:0] box_min_z,
  input  wire logic signed [COORD_BITS-1:0] box_max_x,
  input  wire logic signed [COORD_BITS-1:0] box_max_y,
  input  wire logic signed [COORD_BITS-1:0] box_max_z,
  input  wire logic signed [COORD_BITS-1:0] origin_x,
  input  wire logic signed [COORD_BITS-1:0] origin_y,
  input  wire logic signed [COORD_BITS-1:0] origin_z,
  input  wire logic signed [COORD_BITS-1:0] dir_x,
  input  wire logic signed [COORD_BITS-1:0] dir_y,
  input  wire logic signed [COORD_BITS-1:0] dir_z,
  output logic                              valid,
  output logic                              hit
);
  logic signed [COORD_BITS-1:0] bmin [3];
  logic signed [COORD_BITS-1:0] bmax [3];
  logic signed [COORD_BITS-1:0] org  [3];
  logic signed [COORD_BITS-1:0] dir  [3];
  logic signed [COORD_BITS:0]   lo_num [3];
  logic signed [COORD_BITS:0]   hi_num [3];
  logic signed [COORD_BITS:0]   den    [3];
  rbst_pkg::rbst_flags_t        flags   [3];
  rbst_pkg::rbst_flags_t        flags_d [3];
  logic [8:0]                   le;
  logic [1:0]                   stage_valid;
  logic                         hit_next;

  assign bmin = '{box_min_x, box_min_y, box_min_z};
  assign bmax = '{box_max_x, box_max_y, box_max_z};
  assign org  = '{origin_x, origin_y, origin_z};
  assign dir  = '{dir_x, dir_y, dir_z};

  // The pipeline never holds back, so a beat is taken whenever start is high.
  assign busy = 1'b0;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    rbst_lane #(.COORD_BITS(COORD_BITS)) u_lane (
      .clk    (clk),
      .bmin   (bmin[a]),
      .bmax   (bmax[a]),
      .org    (org[a]),
      .dir    (dir[a]),
      .lo_num (lo_num[a]),
      .hi_num (hi_num[a]),
      .den    (den[a]),
      .flags  (flags[a])
    );

    // The flags travel alongside the product stage.
    always_ff @(posedge clk) begin
      flags_d[a] <= flags[a];
    end
  end

  // Lower end of axis i against upper end of axis j.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      rbst_pair_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
        .clk    (clk),
        .lo_num (lo_num[i]),
        .lo_den (den[i]),
        .hi_num (hi_num[j]),
        .hi_den (den[j]),
        .le     (le[3*i+j])
      );
    end
  end

  // A pair counts only when both axes actually bound t.
  always_comb begin
    hit_next = flags_d[0].pass && flags_d[1].pass && flags_d[2].pass;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (flags_d[i].bounded && flags_d[j].bounded && !le[3*i+j]) begin
          hit_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      valid       <= 1'b0;
      hit         <= 1'b0;
    end else begin
      stage_valid <= {stage_valid[0], start};
      valid       <= stage_valid[1];
      hit         <= stage_valid[1] && hit_next;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/rbst_checker.sv */
// Port-level checker of the ray / box slab test and its bind to the top level.
// Depends on rbst_pkg and ray_box_slab_test_assert.svh.
`default_nettype none
`include "ray_box_slab_test_assert.svh"
module rbst_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic valid,
  input wire logic hit
);
  `RBST_ASSERT_IMP(a_result_follows, clk, rst, start && !busy, ##3 valid)
  `RBST_ASSERT_IMP(a_no_invented, clk, rst, valid, $past(start, rbst_pkg::LATENCY))
  `RBST_ASSERT_IMP(a_hit_only_valid, clk, rst, !valid, !hit)
  `RBST_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .valid (valid),
  .hit   (hit)
);
`default_nettype wire
